@@ src/gpio_expander_edge_irq_regs_assert.svh @@
// assertion macros shared by the gpio expander rtl
`ifndef GPIO_EXPANDER_EDGE_IRQ_REGS_ASSERT_SVH
`define GPIO_EXPANDER_EDGE_IRQ_REGS_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is asserted
`define GPX_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds through reset
`define GPX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPX_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define GPX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/gpx_pkg.sv @@
// types, register map and constants of the gpio expander
package gpx_pkg;

    localparam int PIN_W     = 16;
    localparam int CFG_BYTES = 18;

    // operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // register byte addresses
    localparam logic [6:0] A_CFG_FIRST    = 7'h00;
    localparam logic [6:0] A_CFG_LAST     = 7'h11;
    localparam logic [6:0] A_CFG_RD_LAST  = 7'h0f;
    localparam logic [6:0] A_DATA_HI      = 7'h10;
    localparam logic [6:0] A_DATA_LO      = 7'h11;
    localparam logic [6:0] A_MASK_HI      = 7'h12;
    localparam logic [6:0] A_MASK_LO      = 7'h13;
    localparam logic [6:0] A_SENSE_FIRST  = 7'h14;
    localparam logic [6:0] A_SENSE_LAST   = 7'h17;
    localparam logic [6:0] A_SOURCE_HI    = 7'h18;
    localparam logic [6:0] A_SOURCE_LO    = 7'h19;
    localparam logic [6:0] A_CLOCK        = 7'h1e;
    localparam logic [6:0] A_MISC         = 7'h1f;
    localparam logic [6:0] A_LED_HI       = 7'h20;
    localparam logic [6:0] A_LED_LO       = 7'h21;
    localparam logic [6:0] A_DEBOUNCE_FIRST = 7'h22;
    localparam logic [6:0] A_DEBOUNCE_LAST  = 7'h24;
    localparam logic [6:0] A_RESET        = 7'h7d;

    // soft reset key bytes
    localparam logic [7:0] KEY_FIRST  = 8'h12;
    localparam logic [7:0] KEY_SECOND = 8'h34;

    // pin config word indexes, word k is bytes 2k (pins 15..8) and 2k+1
    localparam int W_PULL_UP    = 3;
    localparam int W_PULL_DOWN  = 4;
    localparam int W_OPEN_DRAIN = 5;
    localparam int W_POLARITY   = 6;
    localparam int W_DIR        = 7;
    localparam int W_DATA       = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  byte_addr;
        logic [7:0]  write_data;
        logic [15:0] pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] out_levels;
        logic [15:0] drive_enable;
        logic [15:0] open_drain_enable;
        logic [15:0] pull_up_enable;
        logic [15:0] pull_down_enable;
        logic        interrupt_n;
    } out_item_t;

    // reset value of one pin config byte: direction and data bytes are all ones
    function automatic logic [7:0] cfg_reset_byte(input int idx);
        logic [7:0] val;
        val = 8'h00;
        if (idx >= 2 * W_DIR) begin
            val = 8'hff;
        end
        return val;
    endfunction

endpackage

@@ src/gpx_edge_detect.sv @@
// per-pin edge detection and interrupt hit mask for one level sample
module gpx_edge_detect #(
    parameter int PIN_COUNT = 16
) (
    input  logic [15:0] pin_levels,
    input  logic [15:0] last_levels,
    input  logic [15:0] polarity,
    input  logic [31:0] edge_sense,
    input  logic [15:0] irq_mask,
    output logic [15:0] levels_masked,
    output logic [15:0] hits
);

    localparam logic [16:0] PinMaskW = (17'd1 << PIN_COUNT) - 17'd1;
    localparam logic [15:0] PinMask  = PinMaskW[15:0];

    logic [15:0] cur;
    logic [15:0] prev;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] raw_hits;

    assign levels_masked = pin_levels & PinMask;
    assign cur  = levels_masked ^ polarity;
    assign prev = last_levels ^ polarity;
    assign rise = cur & ~prev;
    assign fall = prev & ~cur;

    always_comb begin
        raw_hits = '0;
        for (int n = 0; n < PIN_COUNT; n++) begin
            raw_hits[n] = (edge_sense[2 * n] & rise[n]) | (edge_sense[2 * n + 1] & fall[n]);
        end
    end

    assign hits = raw_hits & ~irq_mask & PinMask;

endmodule

@@ src/gpx_regfile.sv @@
// register file: bus read/write decode, sample update and result formation
`include "gpio_expander_edge_irq_regs_assert.svh"

module gpx_regfile #(
    parameter int PIN_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  gpx_pkg::in_item_t  item,
    output gpx_pkg::out_item_t result
);

    localparam logic [16:0] PinMaskW = (17'd1 << PIN_COUNT) - 17'd1;
    localparam logic [15:0] PinMask  = PinMaskW[15:0];

    logic [7:0]  cfg_reg [gpx_pkg::CFG_BYTES];
    logic [7:0]  cfg_next [gpx_pkg::CFG_BYTES];
    logic [15:0] irq_mask_reg, irq_mask_next;
    logic [31:0] edge_sense_reg, edge_sense_next;
    logic [15:0] irq_source_reg, irq_source_next;
    logic [15:0] last_levels_reg, last_levels_next;
    logic [15:0] led_enable_reg, led_enable_next;
    logic [7:0]  debounce_reg [3];
    logic [7:0]  debounce_next [3];
    logic [7:0]  clock_misc_reg [2];
    logic [7:0]  clock_misc_next [2];
    logic        reset_armed_reg, reset_armed_next;

    logic [15:0] pol_cur;
    logic [15:0] levels_masked;
    logic [15:0] hits;
    logic [15:0] data_core;
    logic [7:0]  rd_byte;
    logic [6:0]  a;
    logic [7:0]  d;
    logic [6:0]  deb_off;
    logic        soft_rst;

    assign a       = item.byte_addr;
    assign d       = item.write_data;
    assign deb_off = a - gpx_pkg::A_DEBOUNCE_FIRST;
    assign pol_cur = {cfg_reg[2 * gpx_pkg::W_POLARITY], cfg_reg[2 * gpx_pkg::W_POLARITY + 1]};

    gpx_edge_detect #(
        .PIN_COUNT (PIN_COUNT)
    ) u_edge (
        .pin_levels    (item.pin_levels),
        .last_levels   (last_levels_reg),
        .polarity      (pol_cur),
        .edge_sense    (edge_sense_reg),
        .irq_mask      (irq_mask_reg),
        .levels_masked (levels_masked),
        .hits          (hits)
    );

    // bus read from the state before the item
    assign data_core = (last_levels_reg ^ pol_cur) & PinMask;

    always_comb begin
        rd_byte = 8'h00;
        unique case (a) inside
            [gpx_pkg::A_CFG_FIRST:gpx_pkg::A_CFG_RD_LAST]: rd_byte = cfg_reg[a[4:0]];
            gpx_pkg::A_DATA_HI:   rd_byte = data_core[15:8];
            gpx_pkg::A_DATA_LO:   rd_byte = data_core[7:0];
            gpx_pkg::A_MASK_HI:   rd_byte = irq_mask_reg[15:8];
            gpx_pkg::A_MASK_LO:   rd_byte = irq_mask_reg[7:0];
            [gpx_pkg::A_SENSE_FIRST:gpx_pkg::A_SENSE_LAST]: begin
                rd_byte = 8'(edge_sense_reg >> (5'd8 * (5'd3 - {3'd0, a[1:0]})));
            end
            gpx_pkg::A_SOURCE_HI: rd_byte = irq_source_reg[15:8];
            gpx_pkg::A_SOURCE_LO: rd_byte = irq_source_reg[7:0];
            gpx_pkg::A_CLOCK:     rd_byte = clock_misc_reg[0];
            gpx_pkg::A_MISC:      rd_byte = clock_misc_reg[1];
            gpx_pkg::A_LED_HI:    rd_byte = led_enable_reg[15:8];
            gpx_pkg::A_LED_LO:    rd_byte = led_enable_reg[7:0];
            [gpx_pkg::A_DEBOUNCE_FIRST:gpx_pkg::A_DEBOUNCE_LAST]: begin
                rd_byte = debounce_reg[deb_off[1:0]];
            end
            default:              rd_byte = 8'h00;
        endcase
    end

    // next state for one item
    always_comb begin
        cfg_next         = cfg_reg;
        irq_mask_next    = irq_mask_reg;
        edge_sense_next  = edge_sense_reg;
        irq_source_next  = irq_source_reg;
        last_levels_next = last_levels_reg;
        led_enable_next  = led_enable_reg;
        debounce_next    = debounce_reg;
        clock_misc_next  = clock_misc_reg;
        reset_armed_next = reset_armed_reg;
        soft_rst         = 1'b0;

        if (item.op == gpx_pkg::OP_WRITE) begin
            unique case (a) inside
                gpx_pkg::A_RESET: begin
                    if (reset_armed_reg && d == gpx_pkg::KEY_SECOND) begin
                        soft_rst = 1'b1;
                    end else begin
                        reset_armed_next = (d == gpx_pkg::KEY_FIRST);
                    end
                end
                [gpx_pkg::A_CFG_FIRST:gpx_pkg::A_CFG_LAST]: cfg_next[a[4:0]] = d;
                gpx_pkg::A_MASK_HI: irq_mask_next[15:8] = d;
                gpx_pkg::A_MASK_LO: irq_mask_next[7:0]  = d;
                [gpx_pkg::A_SENSE_FIRST:gpx_pkg::A_SENSE_LAST]: begin
                    // big-endian: lowest address holds bits 31..24
                    case (a[1:0])
                        2'd0:    edge_sense_next[31:24] = d;
                        2'd1:    edge_sense_next[23:16] = d;
                        2'd2:    edge_sense_next[15:8]  = d;
                        default: edge_sense_next[7:0]   = d;
                    endcase
                end
                gpx_pkg::A_SOURCE_HI: irq_source_next = irq_source_reg & ~{d, 8'h00};
                gpx_pkg::A_SOURCE_LO: irq_source_next = irq_source_reg & ~{8'h00, d};
                gpx_pkg::A_CLOCK:     clock_misc_next[0] = d;
                gpx_pkg::A_MISC:      clock_misc_next[1] = d;
                gpx_pkg::A_LED_HI:    led_enable_next[15:8] = d;
                gpx_pkg::A_LED_LO:    led_enable_next[7:0]  = d;
                [gpx_pkg::A_DEBOUNCE_FIRST:gpx_pkg::A_DEBOUNCE_LAST]: begin
                    debounce_next[deb_off[1:0]] = d;
                end
                default: ;
            endcase
        end else if (item.op == gpx_pkg::OP_SAMPLE) begin
            irq_source_next  = irq_source_reg | hits;
            last_levels_next = levels_masked;
        end

        if (soft_rst) begin
            for (int i = 0; i < gpx_pkg::CFG_BYTES; i++) begin
                cfg_next[i] = gpx_pkg::cfg_reset_byte(i);
            end
            irq_mask_next    = '1;
            edge_sense_next  = '0;
            irq_source_next  = '0;
            last_levels_next = '0;
            led_enable_next  = '0;
            debounce_next    = '{default: 8'h00};
            clock_misc_next  = '{default: 8'h00};
            reset_armed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gpx_pkg::CFG_BYTES; i++) begin
                cfg_reg[i] <= gpx_pkg::cfg_reset_byte(i);
            end
            irq_mask_reg    <= '1;
            edge_sense_reg  <= '0;
            irq_source_reg  <= '0;
            last_levels_reg <= '0;
            led_enable_reg  <= '0;
            debounce_reg    <= '{default: 8'h00};
            clock_misc_reg  <= '{default: 8'h00};
            reset_armed_reg <= 1'b0;
        end else if (step) begin
            cfg_reg         <= cfg_next;
            irq_mask_reg    <= irq_mask_next;
            edge_sense_reg  <= edge_sense_next;
            irq_source_reg  <= irq_source_next;
            last_levels_reg <= last_levels_next;
            led_enable_reg  <= led_enable_next;
            debounce_reg    <= debounce_next;
            clock_misc_reg  <= clock_misc_next;
            reset_armed_reg <= reset_armed_next;
        end
    end

    // result shows the state after the item
    always_comb begin
        logic [15:0] pol_n;
        logic [15:0] data_n;
        logic [15:0] dir_n;
        pol_n  = {cfg_next[2 * gpx_pkg::W_POLARITY], cfg_next[2 * gpx_pkg::W_POLARITY + 1]};
        data_n = {cfg_next[2 * gpx_pkg::W_DATA], cfg_next[2 * gpx_pkg::W_DATA + 1]};
        dir_n  = {cfg_next[2 * gpx_pkg::W_DIR], cfg_next[2 * gpx_pkg::W_DIR + 1]};
        result.read_data         = (item.op == gpx_pkg::OP_READ) ? rd_byte : 8'h00;
        result.out_levels        = (data_n ^ pol_n) & PinMask;
        result.drive_enable      = ~dir_n & PinMask;
        result.open_drain_enable = {cfg_next[2 * gpx_pkg::W_OPEN_DRAIN],
                                    cfg_next[2 * gpx_pkg::W_OPEN_DRAIN + 1]} & PinMask;
        result.pull_up_enable    = {cfg_next[2 * gpx_pkg::W_PULL_UP],
                                    cfg_next[2 * gpx_pkg::W_PULL_UP + 1]} & PinMask;
        result.pull_down_enable  = {cfg_next[2 * gpx_pkg::W_PULL_DOWN],
                                    cfg_next[2 * gpx_pkg::W_PULL_DOWN + 1]} & PinMask;
        result.interrupt_n       = ~(|(irq_source_next & PinMask));
    end

    `GPX_ASSERT_CLK(a_src_hold_idle, aclk, aresetn, !step |=> $stable(irq_source_reg), "source changed without an item")
    `GPX_ASSERT_CLK(a_sample_no_clear, aclk, aresetn, step && item.op == gpx_pkg::OP_SAMPLE |=> (irq_source_reg & $past(irq_source_reg)) == $past(irq_source_reg), "sample cleared a source bit")
    `GPX_ASSERT_CLK(a_arm_key, aclk, aresetn, step && item.op == gpx_pkg::OP_WRITE && a == gpx_pkg::A_RESET && d == gpx_pkg::KEY_FIRST |=> reset_armed_reg, "first reset key did not arm")

endmodule

@@ src/gpio_expander_edge_irq_regs.sv @@
// top level of the sixteen-pin gpio expander register block
// One item is a byte bus read, a byte bus write or a pin level sample; every
// item gives exactly one result that shows the register state after it (the
// read byte on a read, zero otherwise, plus the pin drive controls and the
// active-low interrupt). Items are taken at one per cycle while the output is
// not stalled: an item sits in an input register, the register file update and
// result logic work on it, and the result lands in an output register. While a
// result waits on the output, one more item can still be taken into the empty
// input register; after that the input stalls until the result is taken.
// PIN_COUNT limits which pins are sampled and driven; register bits of higher
// pins are still stored. A 0x12 then 0x34 write to 0x7d resets all register
// state.
`include "gpio_expander_edge_irq_regs_assert.svh"

module gpio_expander_edge_irq_regs #(
    parameter int PIN_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gpx_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gpx_pkg::out_item_t m_data
);

    // input register stage
    logic               in_valid_reg, in_valid_next;
    gpx_pkg::in_item_t  in_item_reg;
    // result register stage
    logic               out_valid_reg, out_valid_next;
    gpx_pkg::out_item_t out_item_reg;

    gpx_pkg::out_item_t result;
    logic               adv;   // result register free or being taken
    logic               step;  // input item processed this cycle

    assign adv     = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    gpx_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (step) begin
            out_item_reg <= result;
        end
    end

    `GPX_ASSERT_ALWAYS(a_ready_when_empty, aclk, !in_valid_reg |-> s_ready, "ready low with empty input register")
    `GPX_ASSERT_CLK(a_stall_holds_input, aclk, aresetn, in_valid_reg && !adv |=> in_valid_reg && $stable(in_item_reg), "stalled input item lost")
    `GPX_ASSERT_CLK(a_step_gives_result, aclk, aresetn, step |=> m_valid, "processed item gave no result")

endmodule
